// File: rtl/core/slewed_additive_oscillator_bank_assert.svh
// Assertion macros for the oscillator bank.
`ifndef SLEWED_ADDITIVE_OSCILLATOR_BANK_ASSERT_SVH
`define SLEWED_ADDITIVE_OSCILLATOR_BANK_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SAB_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define SAB_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define SAB_ASSERT_IMP(label, clk, rst_n, a, b)
`define SAB_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// File: rtl/core/sab_pkg.sv
package sab_pkg;

  localparam int DEF_NUM_OSC   = 16;
  localparam int DEF_SINE_BITS = 10;
  localparam int DEF_RATE_HZ   = 48000;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_COMMIT  = 2'd2;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  typedef struct packed {
    logic [31:0] phase;
    logic [31:0] cur_inc;
    logic [31:0] tgt_inc;
    logic [15:0] cur_amp;
    logic [15:0] tgt_amp;
    logic [7:0]  tgt_off;
    logic [31:0] cur_off;
  } osc_t;

  typedef logic [31:0] inc_tbl_t [256];

  function automatic logic [31:0] slew32(logic [31:0] cur, logic [31:0] tgt,
                                         logic [3:0] sh);
    logic [31:0] d;
    logic [31:0] step;
    d = tgt - cur;
    if (d[31]) step = ~((~d) >> sh);
    else step = d >> sh;
    if (step == 32'd0) step = 32'd1;
    return (d == 32'd0) ? cur : cur + step;
  endfunction

  function automatic logic signed [11:0] sine_entry(int i, int bits);
    int quarter;
    int q;
    int r;
    int k;
    int v;
    quarter = 1 << (bits - 2);
    q = i >> (bits - 2);
    r = i & (quarter - 1);
    k = q[0] ? quarter - r : r;
    if (k == 0) v = 0;
    else if (k >= quarter) v = 2047;
    else v = $rtoi(2047.0 * $sin(3.14159265358979323846 * 0.5 * k *
                                  $pow(2.0, -(bits - 2))));
    if (q[1]) v = -v;
    return 12'(v);
  endfunction

  function automatic inc_tbl_t build_inc(real rate_inv);
    inc_tbl_t tbl;
    real t;
    for (int i = 0; i < 256; i++) begin
      t = 20.0 * $pow(500.0, i / 255.0) * 4294967296.0 * rate_inv;
      if (t > 4294967295.0) tbl[i] = 32'hFFFF_FFFF;
      else tbl[i] = 32'(longint'($floor(t)));
    end
    return tbl;
  endfunction

endpackage

// File: rtl/core/sab_vram.sv
module sab_vram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);
  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     rd_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (rd_en) rvld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rvld_r ? rd_r : '0;
endmodule

// File: rtl/core/sab_sine_rom.sv
module sab_sine_rom #(
  parameter int BITS = 10
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [BITS-1:0]        addr,
  output logic signed [11:0]     data
);
  import sab_pkg::*;
  localparam int SIZE = 1 << BITS;
  typedef logic signed [11:0] sine_tbl_t [SIZE];

  function automatic sine_tbl_t build_sine();
    sine_tbl_t t;
    for (int i = 0; i < SIZE; i++) t[i] = sine_entry(i, BITS);
    return t;
  endfunction

  localparam sine_tbl_t SINE = build_sine();

  always_ff @(posedge clk) begin
    if (rd_en) data <= SINE[addr];
  end
endmodule

// File: rtl/core/sab_divider.sv
module sab_divider #(
  parameter int DW = 18,
  parameter int VW = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic [VW-1:0]        divisor,
  output logic                 done,
  output logic signed [DW-1:0] quotient
);
  localparam int CNW = $clog2(DW + 1);
  logic          busy_r;
  logic          done_r;
  logic [CNW-1:0] cnt_r;
  logic [DW-1:0] q_r;
  logic [VW:0]   rem_r;
  logic [VW-1:0] dv_r;
  logic          neg_r;
  logic [VW:0]   tmp;

  assign tmp = {rem_r[VW-1:0], q_r[DW-1]};

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend[DW-1] ? -dividend : dividend;
      neg_r <= dividend[DW-1];
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      if (tmp >= {1'b0, dv_r}) begin
        rem_r <= tmp - {1'b0, dv_r};
        q_r   <= {q_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= tmp;
        q_r   <= {q_r[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule

// File: rtl/core/slewed_additive_oscillator_bank.sv
// Bank of sine oscillators with slewed frequency, amplitude and phase offset,
// mixed into one 12-bit sample per tick word. Write-cell words go straight to
// the grid memory; a commit word walks the oscillators through the CRD and CWR
// states; a tick word takes each oscillator through RD, SLEW, MUL, WB and ACC
// on the state memory, then the sum goes through the bit-serial divider, or in
// test tone mode one sine ROM read is taken instead. A result waits in the
// output register while the next word is taken.
module slewed_additive_oscillator_bank #(
  parameter int NUM_OSCILLATORS = sab_pkg::DEF_NUM_OSC,
  parameter int SINE_TABLE_BITS = sab_pkg::DEF_SINE_BITS,
  parameter int SAMPLE_RATE_HZ  = sab_pkg::DEF_RATE_HZ
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [11:0] in_fm_sample,
  input  logic               in_fm_connected,
  input  logic [3:0]         in_cell_index,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic [4:0]         in_active_count,
  input  logic [7:0]         in_slew,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [11:0] out_audio_out
);
  import sab_pkg::*;
  `include "slewed_additive_oscillator_bank_assert.svh"

  localparam int IW    = (NUM_OSCILLATORS > 1) ? $clog2(NUM_OSCILLATORS) : 1;
  localparam int CW    = $clog2(NUM_OSCILLATORS + 1);
  localparam int ACC_W = 13 + CW;
  localparam int OW    = $bits(osc_t);
  localparam real RATE_INV = 1.0 / SAMPLE_RATE_HZ;
  localparam inc_tbl_t INC_ROM = build_inc(RATE_INV);
  localparam logic [31:0] TONE_INC = INC_ROM[128];

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_SLEW   = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_WB     = 4'd4;
  localparam logic [3:0] S_ACC    = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DWAIT  = 4'd7;
  localparam logic [3:0] S_TONE   = 4'd8;
  localparam logic [3:0] S_TCAP   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;
  localparam logic [3:0] S_CRD    = 4'd11;
  localparam logic [3:0] S_CWR    = 4'd12;

  logic [3:0]              st_r, st_nxt;
  logic [CW-1:0]           idx_r;
  logic signed [11:0]      fm_r;
  logic [CW-1:0]           active_r;
  logic [3:0]              shift_r;
  logic                    grid_rcv_r;
  logic [31:0]             tone_r;
  osc_t                    work_r;
  logic [31:0]             prod_r;
  logic signed [20:0]      sprod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] mix_r;
  logic                    out_valid_r;
  logic signed [11:0]      out_data_r;

  logic        in_acc, mix_mode, osc_en, last_idx, can_load;
  logic        grid_wr, osc_wr, osc_rd_en, rom_rd_en, div_done;
  logic [23:0] grid_rd;
  osc_t        osc_rd, osc_wd, slewed;
  logic [31:0] phsum, adv;
  logic [SINE_TABLE_BITS-1:0] rom_addr;
  logic signed [11:0] rom_data;
  logic signed [ACC_W-1:0] div_q;
  logic signed [43:0] fm_prod;
  logic [11:0] slew15;

  assign in_stall  = (st_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign mix_mode  = grid_rcv_r && (active_r != '0);
  assign osc_en    = mix_mode && (idx_r < active_r);
  assign last_idx  = (idx_r == CW'(NUM_OSCILLATORS - 1));
  assign can_load  = !out_valid_r || !out_stall;
  assign grid_wr   = in_acc && (in_command == CMD_WRITE) &&
                     ({28'd0, in_cell_index} < 32'(NUM_OSCILLATORS));
  assign osc_rd_en = (st_r == S_RD) || (st_r == S_CRD);
  assign osc_wr    = (st_r == S_WB) || (st_r == S_CWR);
  assign rom_rd_en = (st_r == S_MUL) || (st_r == S_TONE);
  assign phsum     = work_r.phase + work_r.cur_off;
  assign rom_addr  = (st_r == S_TONE) ? tone_r[31 -: SINE_TABLE_BITS]
                                      : phsum[31 -: SINE_TABLE_BITS];
  assign adv       = work_r.cur_inc + 32'($signed(prod_r) >>> 7);
  assign fm_prod   = $signed(work_r.cur_inc) * fm_r;
  assign slew15    = {4'd0, in_slew} * 12'd15;

  always_comb begin
    slewed         = osc_rd;
    slewed.cur_inc = slew32(osc_rd.cur_inc, osc_rd.tgt_inc, shift_r);
    slewed.cur_amp = 16'(slew32({16'd0, osc_rd.cur_amp}, {16'd0, osc_rd.tgt_amp},
                                shift_r));
    slewed.cur_off = slew32(osc_rd.cur_off, {osc_rd.tgt_off, 24'd0}, shift_r);
  end

  always_comb begin
    osc_wd = osc_rd;
    if (st_r == S_WB) begin
      osc_wd = work_r;
      if (osc_en && adv != 32'd0 && !adv[31]) osc_wd.phase = work_r.phase + adv;
    end else if (idx_r < active_r) begin
      osc_wd.tgt_inc = INC_ROM[grid_rd[23:16]];
      osc_wd.tgt_amp = {grid_rd[15:8], 8'd0};
      osc_wd.tgt_off = grid_rd[7:0];
    end else begin
      osc_wd.tgt_amp = 16'd0;
    end
  end

  sab_vram #(.W(24), .DEPTH(NUM_OSCILLATORS), .AW(IW)) u_grid (
    .clk(clk), .rst_n(rst_n),
    .wr_en(grid_wr), .wr_addr(IW'(in_cell_index)),
    .wr_data({in_red, in_green, in_blue}),
    .rd_en(st_r == S_CRD), .rd_addr(idx_r[IW-1:0]), .rd_data(grid_rd)
  );

  sab_vram #(.W(OW), .DEPTH(NUM_OSCILLATORS), .AW(IW)) u_osc (
    .clk(clk), .rst_n(rst_n),
    .wr_en(osc_wr), .wr_addr(idx_r[IW-1:0]), .wr_data(osc_wd),
    .rd_en(osc_rd_en), .rd_addr(idx_r[IW-1:0]), .rd_data(osc_rd)
  );

  sab_sine_rom #(.BITS(SINE_TABLE_BITS)) u_sine (
    .clk(clk), .rd_en(rom_rd_en), .addr(rom_addr), .data(rom_data)
  );

  sab_divider #(.DW(ACC_W), .VW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(st_r == S_DSTART),
    .dividend(acc_r), .divisor(active_r), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc && in_command == CMD_TICK) st_nxt = S_RD;
        else if (in_acc && in_command == CMD_COMMIT) st_nxt = S_CRD;
      end
      S_RD:     st_nxt = S_SLEW;
      S_SLEW:   st_nxt = S_MUL;
      S_MUL:    st_nxt = S_WB;
      S_WB:     st_nxt = S_ACC;
      S_ACC: begin
        if (!last_idx) st_nxt = S_RD;
        else if (mix_mode) st_nxt = S_DSTART;
        else st_nxt = S_TONE;
      end
      S_DSTART: st_nxt = S_DWAIT;
      S_DWAIT:  if (div_done) st_nxt = S_OUT;
      S_TONE:   st_nxt = S_TCAP;
      S_TCAP:   st_nxt = S_OUT;
      S_OUT:    if (can_load) st_nxt = S_IDLE;
      S_CRD:    st_nxt = S_CWR;
      S_CWR:    st_nxt = last_idx ? S_IDLE : S_CRD;
      default:  st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      idx_r       <= '0;
      active_r    <= '0;
      shift_r     <= 4'd4;
      grid_rcv_r  <= 1'b0;
      tone_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_OUT && can_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (in_acc && in_command == CMD_TICK) begin
        idx_r <= '0;
      end else if (in_acc && in_command == CMD_COMMIT) begin
        idx_r      <= '0;
        grid_rcv_r <= 1'b1;
        shift_r    <= 4'd1 + slew15[11:8];
        if ({27'd0, in_active_count} > 32'(NUM_OSCILLATORS))
          active_r <= CW'(NUM_OSCILLATORS);
        else active_r <= CW'(in_active_count);
      end
      if ((st_r == S_ACC || st_r == S_CWR) && !last_idx) idx_r <= idx_r + 1'b1;
      if (st_r == S_TCAP) tone_r <= tone_r + TONE_INC;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_command == CMD_TICK) begin
      fm_r  <= in_fm_connected ? in_fm_sample : 12'sd0;
      acc_r <= '0;
    end
    if (st_r == S_SLEW) work_r <= slewed;
    if (st_r == S_MUL) prod_r <= fm_prod[31:0];
    if (st_r == S_WB) sprod_r <= rom_data * $signed({1'b0, work_r.cur_amp[15:8]});
    if (st_r == S_ACC && osc_en) acc_r <= acc_r + ACC_W'(sprod_r >>> 8);
    if (st_r == S_DWAIT && div_done) mix_r <= div_q;
    if (st_r == S_TCAP) mix_r <= ACC_W'(rom_data);
    if (st_r == S_OUT && can_load) begin
      if (mix_r > ACC_W'(2047)) out_data_r <= 12'sd2047;
      else if (mix_r < -ACC_W'(2048)) out_data_r <= -12'sd2048;
      else out_data_r <= 12'(mix_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_audio_out = out_data_r;

  `SAB_ASSERT_NXT(a_loop_end, clk, rst_n, (st_r == S_ACC && last_idx), (st_r == S_DSTART || st_r == S_TONE))
  `SAB_ASSERT_IMP(a_out_src, clk, rst_n, $rose(out_valid_r), ($past(st_r) == S_OUT))
  `SAB_ASSERT_IMP(a_wr_state, clk, rst_n, osc_wr, (st_r == S_WB || st_r == S_CWR))
endmodule

// File: bench/tb_top.sv
module tb_top;
  import sab_pkg::*;

  localparam int NOSC = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_WORDS = 1530;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [11:0] fm;
    logic               fmc;
    logic [3:0]         cidx;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [4:0]         cnt;
    logic [7:0]         slew;
    bit                 has_exp;
    logic signed [11:0] exp_val;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = CMD_TICK;
  logic signed [11:0] in_fm_sample = '0;
  logic in_fm_connected = 1'b0;
  logic [3:0] in_cell_index = '0;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic [4:0] in_active_count = '0;
  logic [7:0] in_slew = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [11:0] out_audio_out;

  slewed_additive_oscillator_bank uut (.*);

  always #5 clk = ~clk;

  // bank model
  logic signed [11:0] sine_tab [1024];
  logic [31:0] inc_tab [256];
  logic [23:0] grid [NOSC];
  logic [31:0] phase [NOSC];
  logic [31:0] tgt_inc [NOSC];
  logic [31:0] cur_inc [NOSC];
  logic [31:0] tgt_amp [NOSC];
  logic [31:0] cur_amp [NOSC];
  logic [7:0]  tgt_off [NOSC];
  logic [31:0] cur_off [NOSC];
  int unsigned n_active;
  int unsigned shift_amt;
  bit grid_seen;
  logic [31:0] tone_phase;

  logic signed [11:0] audio_q [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  task automatic report(input string msg);
    if (errors < 50) $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic logic [31:0] step_toward(logic [31:0] cur, logic [31:0] tgt,
                                              int unsigned sh);
    logic [31:0] d;
    logic [31:0] st;
    d = tgt - cur;
    if (d == 0) return cur;
    if (d[31]) st = ~((~d) >> sh);
    else st = d >> sh;
    if (st == 0) st = 1;
    return cur + st;
  endfunction

  task automatic init_bank();
    int q;
    int r;
    int k;
    int v;
    real t;
    for (int i = 0; i < 1024; i++) begin
      q = i / 256;
      r = i % 256;
      k = (q % 2 == 1) ? 256 - r : r;
      if (k == 0) v = 0;
      else if (k >= 256) v = 2047;
      else v = $rtoi(2047.0 * $sin(3.14159265358979323846 * k / 512.0));
      if (q >= 2) v = -v;
      sine_tab[i] = 12'(v);
    end
    for (int i = 0; i < 256; i++) begin
      t = 20.0 * $pow(500.0, i / 255.0) * 4294967296.0 / 48000.0;
      if (t > 4294967295.0) inc_tab[i] = 32'hFFFF_FFFF;
      else inc_tab[i] = 32'(longint'($floor(t)));
    end
    for (int i = 0; i < NOSC; i++) begin
      grid[i] = 0; phase[i] = 0; tgt_inc[i] = 0; cur_inc[i] = 0;
      tgt_amp[i] = 0; cur_amp[i] = 0; tgt_off[i] = 0; cur_off[i] = 0;
    end
    n_active = 0;
    shift_amt = 4;
    grid_seen = 0;
    tone_phase = 0;
  endtask

  task automatic advance_bank(input word_t w, output bit produced,
                              output logic signed [11:0] sample);
    longint fmv;
    longint acc;
    longint s;
    longint amp;
    longint inc;
    longint prod;
    logic [63:0] p64;
    logic [63:0] a64;
    logic [31:0] adv;
    logic [31:0] ph;
    longint mix;
    produced = 0;
    sample = 0;
    case (w.cmd)
      CMD_WRITE: grid[w.cidx] = {w.red, w.green, w.blue};
      CMD_COMMIT: begin
        n_active = (w.cnt > NOSC) ? NOSC : w.cnt;
        grid_seen = 1;
        shift_amt = 1 + ((w.slew * 15) >> 8);
        for (int i = 0; i < NOSC; i++) begin
          if (i < n_active) begin
            tgt_inc[i] = inc_tab[grid[i][23:16]];
            tgt_amp[i] = {16'd0, grid[i][15:8], 8'd0};
            tgt_off[i] = grid[i][7:0];
          end else begin
            tgt_amp[i] = 0;
          end
        end
      end
      CMD_TICK: begin
        produced = 1;
        for (int i = 0; i < NOSC; i++) begin
          cur_inc[i] = step_toward(cur_inc[i], tgt_inc[i], shift_amt);
          cur_amp[i] = step_toward(cur_amp[i], tgt_amp[i], shift_amt) & 32'hFFFF;
          cur_off[i] = step_toward(cur_off[i], {tgt_off[i], 24'd0}, shift_amt);
        end
        if (grid_seen && n_active > 0) begin
          fmv = w.fmc ? longint'(w.fm) : 0;
          acc = 0;
          for (int i = 0; i < n_active; i++) begin
            ph = phase[i] + cur_off[i];
            s = longint'(sine_tab[ph[31:22]]);
            amp = longint'(cur_amp[i] >> 8);
            inc = longint'($signed(cur_inc[i]));
            p64 = inc * fmv;
            prod = longint'($signed(p64[31:0]));
            a64 = inc + (prod >>> 7);
            adv = a64[31:0];
            acc += (s * amp) >>> 8;
            if (adv != 0 && !adv[31]) phase[i] += adv;
          end
          mix = acc / longint'(n_active);
        end else begin
          mix = sine_tab[tone_phase[31:22]];
          tone_phase += inc_tab[128];
        end
        if (mix < -2048) mix = -2048;
        if (mix > 2047) mix = 2047;
        sample = mix[11:0];
      end
      default: ;
    endcase
  endtask

  function automatic word_t mk(logic [1:0] cmd, logic signed [11:0] fm, logic fmc,
                               logic [3:0] cidx, logic [7:0] r, logic [7:0] g,
                               logic [7:0] b, logic [4:0] cnt, logic [7:0] slew,
                               bit has_exp = 0, logic signed [11:0] ev = 0);
    word_t w;
    w.cmd = cmd; w.fm = fm; w.fmc = fmc; w.cidx = cidx; w.red = r; w.green = g;
    w.blue = b; w.cnt = cnt; w.slew = slew; w.has_exp = has_exp; w.exp_val = ev;
    return w;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int r;
    w = mk(CMD_TICK, 12'($urandom), 1'($urandom_range(1)), 4'($urandom),
           8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
    r = $urandom_range(99);
    if (r < 55) w.cmd = CMD_TICK;
    else if (r < 85) w.cmd = CMD_WRITE;
    else if (r < 96) begin
      w.cmd = CMD_COMMIT;
      if ($urandom_range(9) != 0) w.cnt = 5'($urandom_range(16, 1));
    end else w.cmd = CMD_IGNORED;
    return w;
  endfunction

  task automatic send_word(input word_t w);
    bit produced;
    logic signed [11:0] sample;
    in_valid <= 1'b1;
    in_command <= w.cmd;
    in_fm_sample <= w.fm;
    in_fm_connected <= w.fmc;
    in_cell_index <= w.cidx;
    in_red <= w.red;
    in_green <= w.green;
    in_blue <= w.blue;
    in_active_count <= w.cnt;
    in_slew <= w.slew;
    do @(posedge clk); while (in_stall);
    advance_bank(w, produced, sample);
    if (produced) audio_q.push_back(w.has_exp ? w.exp_val : sample);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    logic signed [11:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (audio_q.size() == 0) begin
        report($sformatf("unexpected audio word %0d", out_audio_out));
      end else begin
        want = audio_q.pop_front();
        if (out_audio_out !== want)
          report($sformatf("audio_out %0d, want %0d", out_audio_out, want));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    word_t dir [$];
    int pct_send [4];
    int pct_recv [4];
    init_bank();
    pct_send = '{0, 57, 0, 36};
    pct_recv = '{0, 0, 57, 36};
    // after reset: test tone starts at phase zero
    dir.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    dir.push_back(mk(CMD_TICK, 12'sh7FF, 1, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(CMD_IGNORED, 12'sh800, 1, 4'hF, 8'hFF, 8'hFF, 8'hFF, 5'h1F, 8'hFF));
    // zero grid, one oscillator: silent
    dir.push_back(mk(CMD_COMMIT, 0, 0, 0, 0, 0, 0, 1, 0));
    dir.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    dir.push_back(mk(CMD_WRITE, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 0, 0));
    dir.push_back(mk(CMD_WRITE, 0, 0, 4'hF, 8'h00, 8'hFF, 8'h00, 0, 0));
    dir.push_back(mk(CMD_WRITE, 0, 0, 1, 8'h80, 8'h80, 8'h40, 0, 0));
    dir.push_back(mk(CMD_WRITE, 0, 0, 2, 8'h00, 8'hFF, 8'hFF, 0, 0));
    dir.push_back(mk(CMD_COMMIT, 0, 0, 0, 0, 0, 0, 5'd31, 8'd0));
    dir.push_back(mk(CMD_TICK, 12'sh800, 1, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(CMD_TICK, 12'sh7FF, 1, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(CMD_TICK, 12'sh800, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(CMD_TICK, 12'sh001, 1, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(CMD_COMMIT, 0, 0, 0, 0, 0, 0, 5'd3, 8'd255));
    dir.push_back(mk(CMD_TICK, 12'shFFF, 1, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    // count zero falls back to the tone
    dir.push_back(mk(CMD_COMMIT, 0, 0, 0, 0, 0, 0, 5'd0, 8'd128));
    dir.push_back(mk(CMD_TICK, 0, 1, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(CMD_TICK, 0, 1, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(CMD_COMMIT, 0, 0, 0, 0, 0, 0, 5'd16, 8'd17));
    dir.push_back(mk(CMD_TICK, 12'sh400, 1, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(CMD_TICK, 12'shC00, 1, 0, 0, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir[i]) send_word(dir[i]);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pct_send[ph];
      recv_stall_pct = pct_recv[ph];
      for (int n = 0; n < RANDOM_WORDS / 4; n++) send_word(rand_word());
      if (ph == 1) begin
        in_valid <= 1'b0;
        while (audio_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    while (audio_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: slewed_additive_oscillator_bank.f
+incdir+rtl/core
rtl/core/sab_pkg.sv
rtl/core/sab_vram.sv
rtl/core/sab_sine_rom.sv
rtl/core/sab_divider.sv
rtl/core/slewed_additive_oscillator_bank.sv
bench/tb_top.sv
